@@ rtl/cef_pkg.sv @@
// Package: shared types and constants for the cluster endpoint finder.
package cef_pkg;

    localparam int MAX_HITS  = 64;
    localparam int IDX_W     = $clog2(MAX_HITS);
    localparam int CNT_W     = $clog2(MAX_HITS + 1);
    localparam int COORD_W   = 20;
    localparam int DIST_W    = 42;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_NEIGHBOUR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR      = 1'd1;

    typedef struct packed {
        logic signed [COORD_W-1:0] hit_x;
        logic signed [COORD_W-1:0] hit_y;
        logic signed [COORD_W-1:0] from_x;
        logic signed [COORD_W-1:0] from_y;
        logic                      last_hit;
    } cef_in_t;

    typedef struct packed {
        logic                      found_two;
        logic [6:0]                endpoint_count;
        logic                      first_valid;
        logic [5:0]                first_index;
        logic signed [COORD_W-1:0] first_x;
        logic signed [COORD_W-1:0] first_y;
        logic                      second_valid;
        logic [5:0]                second_index;
        logic signed [COORD_W-1:0] second_x;
        logic signed [COORD_W-1:0] second_y;
        logic                      overflow;
    } cef_out_t;

    // Search job handed from the loader to the search engine.
    typedef struct packed {
        logic signed [COORD_W-1:0] from_x;
        logic signed [COORD_W-1:0] from_y;
        logic [CNT_W-1:0]          count;
        logic                      dropped;
    } cef_job_t;

    // Squared distance of two points; each product is 21x21 bits.
    function automatic logic [DIST_W-1:0] dist_sq(
        input logic signed [COORD_W-1:0] ax,
        input logic signed [COORD_W-1:0] ay,
        input logic signed [COORD_W-1:0] bx,
        input logic signed [COORD_W-1:0] by
    );
        logic signed [COORD_W:0] dx;
        logic signed [COORD_W:0] dy;
        logic [COORD_W:0] ux;
        logic [COORD_W:0] uy;
        logic [DIST_W-1:0] sq_x;
        logic [DIST_W-1:0] sq_y;
        dx = $signed({ax[COORD_W-1], ax}) - $signed({bx[COORD_W-1], bx});
        dy = $signed({ay[COORD_W-1], ay}) - $signed({by[COORD_W-1], by});
        ux = dx[COORD_W] ? (COORD_W+1)'(-dx) : dx;
        uy = dy[COORD_W] ? (COORD_W+1)'(-dy) : dy;
        sq_x = ux * ux;
        sq_y = uy * uy;
        return sq_x + sq_y;
    endfunction

endpackage

@@ rtl/cef_loader.sv @@
// Front end: store hits, count them, and queue a search job on the last hit.
module cef_loader
    import cef_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  cef_in_t          item,
    output logic             busy,
    output logic             wr_en,
    output logic [IDX_W-1:0] wr_addr,
    output logic             job_valid,
    output cef_job_t         job,
    input  logic             job_taken,
    input  logic             engine_idle
);

    logic [CNT_W-1:0] count_reg;
    logic             dropped_reg;
    logic             job_valid_reg;
    cef_job_t         job_reg;
    logic             accept;
    logic             store_full;

    // Hold off new hits while a job waits or the engine still reads the store.
    assign busy       = job_valid_reg || !engine_idle;
    assign accept     = start && !busy;
    assign store_full = (count_reg == CNT_W'(MAX_HITS));
    assign wr_en      = accept && !store_full;
    assign wr_addr    = count_reg[IDX_W-1:0];
    assign job_valid  = job_valid_reg;
    assign job        = job_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            job_valid_reg <= 1'b0;
        end
        else
        begin
            if (job_taken)
                job_valid_reg <= 1'b0;
            if (accept)
            begin
                if (item.last_hit)
                begin
                    job_valid_reg   <= 1'b1;
                    job_reg.from_x  <= item.from_x;
                    job_reg.from_y  <= item.from_y;
                    job_reg.count   <= store_full ? count_reg : count_reg + 1'b1;
                    job_reg.dropped <= dropped_reg || store_full;
                    count_reg       <= '0;
                    dropped_reg     <= 1'b0;
                end
                else if (store_full)
                    dropped_reg <= 1'b1;
                else
                    count_reg <= count_reg + 1'b1;
            end
        end
    end

    a_job_not_lost: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid_reg && !job_taken |=> job_valid_reg)
        else $error("job dropped before taken");
    a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !wr_en)
        else $error("store written while busy");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_HITS))
        else $error("hit count beyond capacity");

endmodule

@@ rtl/cef_engine.sv @@
// Back end: all-pairs neighbour count and endpoint selection over the store.
module cef_engine
    import cef_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  logic [IDX_W-1:0]    wr_addr,
    input  logic signed [COORD_W-1:0] wr_x,
    input  logic signed [COORD_W-1:0] wr_y,
    input  logic [DIST_W-1:0]   nb_sq,
    input  logic [DIST_W-1:0]   near_sq,
    input  logic                job_valid,
    input  cef_job_t            job,
    output logic                job_taken,
    output logic                idle,
    output logic                done,
    output cef_out_t            result
);

    typedef enum logic [2:0] {S_IDLE, S_READ, S_DIST, S_CMP, S_EP, S_OUT} state_t;

    logic [2*COORD_W-1:0] mem [MAX_HITS];
    logic [2*COORD_W-1:0] rd_i_reg, rd_j_reg;
    state_t state_reg;
    cef_job_t job_reg;
    logic [IDX_W-1:0] i_reg, j_reg;
    logic [CNT_W-1:0] links_reg;
    logic [DIST_W-1:0] d_reg, near_best_reg, far_best_reg;
    logic fv_reg, sv_reg, pair_reg, last_j_reg;
    logic [IDX_W-1:0] fi_reg, si_reg;
    logic [2*COORD_W-1:0] fp_reg, sp_reg;
    logic [CNT_W-1:0] ep_count_reg;
    logic done_reg;
    cef_out_t result_reg;
    logic [DIST_W-1:0] d_ref;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= {wr_x, wr_y};
        rd_i_reg <= mem[i_reg];
        rd_j_reg <= mem[j_reg];
    end

    assign job_taken = (state_reg == S_IDLE) && job_valid;
    assign idle = (state_reg == S_IDLE);
    assign done = done_reg;
    assign result = result_reg;
    assign d_ref = dist_sq(rd_i_reg[2*COORD_W-1:COORD_W], rd_i_reg[COORD_W-1:0],
                           job_reg.from_x, job_reg.from_y);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        job_reg <= job;
                        i_reg <= '0; j_reg <= '0; links_reg <= '0;
                        fv_reg <= 1'b0; sv_reg <= 1'b0; ep_count_reg <= '0;
                        fi_reg <= '0; si_reg <= '0; fp_reg <= '0; sp_reg <= '0;
                        near_best_reg <= '0; far_best_reg <= '0;
                        state_reg <= (job.count == '0) ? S_OUT : S_READ;
                    end
                end
                S_READ:
                begin
                    // Memory read of (i, j) is registered here for use in S_DIST.
                    pair_reg   <= (i_reg != j_reg);
                    last_j_reg <= ({1'b0, j_reg} == job_reg.count - 1'b1);
                    state_reg  <= S_DIST;
                end
                S_DIST:
                begin
                    d_reg <= dist_sq(rd_i_reg[2*COORD_W-1:COORD_W], rd_i_reg[COORD_W-1:0],
                                     rd_j_reg[2*COORD_W-1:COORD_W], rd_j_reg[COORD_W-1:0]);
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (pair_reg && d_reg < nb_sq)
                        links_reg <= links_reg + 1'b1;
                    if (last_j_reg)
                        state_reg <= S_EP;
                    else
                    begin
                        j_reg <= j_reg + 1'b1;
                        state_reg <= S_READ;
                    end
                end
                S_EP:
                begin
                    if (links_reg == CNT_W'(1))
                    begin
                        ep_count_reg <= ep_count_reg + 1'b1;
                        if ((!fv_reg && d_ref < near_sq) || (fv_reg && d_ref < near_best_reg))
                        begin
                            fv_reg <= 1'b1; near_best_reg <= d_ref;
                            fi_reg <= i_reg; fp_reg <= rd_i_reg;
                        end
                        if (!sv_reg || d_ref > far_best_reg)
                        begin
                            sv_reg <= 1'b1; far_best_reg <= d_ref;
                            si_reg <= i_reg; sp_reg <= rd_i_reg;
                        end
                    end
                    links_reg <= '0;
                    j_reg <= '0;
                    if ({1'b0, i_reg} == job_reg.count - 1'b1)
                        state_reg <= S_OUT;
                    else
                    begin
                        i_reg <= i_reg + 1'b1;
                        state_reg <= S_READ;
                    end
                end
                S_OUT:
                begin
                    result_reg.found_two      <= (ep_count_reg == CNT_W'(2));
                    result_reg.endpoint_count <= 7'(ep_count_reg);
                    result_reg.first_valid    <= fv_reg;
                    result_reg.first_index    <= 6'(fi_reg);
                    result_reg.first_x        <= fp_reg[2*COORD_W-1:COORD_W];
                    result_reg.first_y        <= fp_reg[COORD_W-1:0];
                    result_reg.second_valid   <= sv_reg;
                    result_reg.second_index   <= 6'(si_reg);
                    result_reg.second_x       <= sp_reg[2*COORD_W-1:COORD_W];
                    result_reg.second_y       <= sp_reg[COORD_W-1:0];
                    result_reg.overflow       <= job_reg.dropped;
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe longer than one cycle");
    a_first_implies_second: assert property (@(posedge clk) disable iff (!rst_n)
        fv_reg |-> sv_reg)
        else $error("nearest endpoint without farthest");
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        job_taken |=> state_reg != S_IDLE)
        else $error("job taken but engine stayed idle");

endmodule

@@ rtl/cluster_endpoint_finder.sv @@
// Top level: cluster endpoint finder with loader front end and search engine.
// Search: after the last hit is accepted, the engine steps through S_READ, S_DIST and
//   S_CMP for each of the n*n ordered pairs of n stored hits, and through S_EP once per hit.
// Throughput: hits load one per cycle while busy is low; busy stays high through each search.
// Reset: rst_n clears counters, flags and state; the hit store is not cleared.
// The result strobe is a single-cycle pulse; the receiver cannot stall.
module cluster_endpoint_finder
    import cef_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  cef_in_t              item,
    output logic                 busy,
    output logic                 done,
    output cef_out_t             result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIST_W-1:0]    cfg_data
);

    logic [DIST_W-1:0] nb_sq_reg;
    logic [DIST_W-1:0] near_sq_reg;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic              job_valid;
    logic              job_taken;
    logic              engine_idle;
    cef_job_t          job;

    // Configuration registers; the user must write them only while the block is idle; the block does not enforce it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nb_sq_reg   <= DIST_W'(65536);
            near_sq_reg <= DIST_W'(64'd65536000000);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_NEIGHBOUR: nb_sq_reg   <= cfg_data;
                REG_NEAR:      near_sq_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Front end: take hits and hand a job per cluster to the engine.
    cef_loader u_loader (
        .clk, .rst_n, .start, .item, .busy, .wr_en, .wr_addr,
        .job_valid, .job, .job_taken, .engine_idle
    );

    // Back end: pairwise neighbour counting and endpoint selection.
    cef_engine u_engine (
        .clk, .rst_n, .wr_en, .wr_addr,
        .wr_x(item.hit_x), .wr_y(item.hit_y),
        .nb_sq(nb_sq_reg), .near_sq(near_sq_reg),
        .job_valid, .job, .job_taken, .idle(engine_idle), .done, .result
    );

endmodule

@@ dv/tb.sv @@
// Testbench for the cluster endpoint finder: directed and random clusters against a predictor.
`timescale 1ns / 100ps

module tb;
    import cef_pkg::*;

    localparam int       MISMATCH_SHOW = 10;
    localparam longint   CYCLE_LIMIT   = 2000000;
    localparam int       DRAIN_CYCLES  = 3 * MAX_HITS * MAX_HITS + MAX_HITS + 2;
    localparam int       FULL_RANGE    = 1 << (COORD_W - 1);

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    cef_in_t              item;
    logic                 busy;
    logic                 done;
    cef_out_t             result;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DIST_W-1:0]    cfg_data;

    cluster_endpoint_finder DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (item),
        .busy      (busy),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the hit store and the registers.
    // ------------------------------------------------------------------
    logic [DIST_W-1:0] link_limit_sq;
    logic [DIST_W-1:0] near_cut_sq;
    int                pos_x [MAX_HITS];
    int                pos_y [MAX_HITS];
    int                stored_hits;
    bit                hits_dropped;

    cef_out_t          endpoint_q[$];   // expected endpoint summaries, oldest first

    // Run statistics for the closing summary
    int     clusters_sent;
    int     hits_sent;
    int     results_seen;
    int     overflow_seen;
    int     found_two_seen;
    int     mismatches;
    longint cycle_count;

    // Burst shaping of the sender
    int burst_left;

    function automatic longint span_sq(int ax, int ay, int bx, int by);
        longint dx;
        longint dy;
        dx = longint'(ax) - longint'(bx);
        dy = longint'(ay) - longint'(by);
        return dx * dx + dy * dy;
    endfunction

    // Absorb one hit into the predictor; a closing hit yields the summary.
    task automatic absorb_hit(input cef_in_t h, output bit closes, output cef_out_t summary);
        int     links [MAX_HITS];
        int     ends;
        bit     near_ok;
        bit     far_ok;
        int     near_idx;
        int     far_idx;
        longint near_best;
        longint far_best;
        longint d;
        int     rx;
        int     ry;
        closes    = 1'b0;
        summary   = '0;
        ends      = 0;
        near_ok   = 1'b0;
        far_ok    = 1'b0;
        near_idx  = 0;
        far_idx   = 0;
        near_best = 0;
        far_best  = 0;
        if (stored_hits < MAX_HITS)
        begin
            pos_x[stored_hits] = int'(h.hit_x);
            pos_y[stored_hits] = int'(h.hit_y);
            stored_hits++;
        end
        else
            hits_dropped = 1'b1;
        if (!h.last_hit)
            return;
        closes = 1'b1;
        rx = int'(h.from_x);
        ry = int'(h.from_y);
        // neighbour count of every stored hit
        for (int i = 0; i < stored_hits; i++)
        begin
            links[i] = 0;
            for (int j = 0; j < stored_hits; j++)
                if (i != j && span_sq(pos_x[i], pos_y[i], pos_x[j], pos_y[j]) < longint'(link_limit_sq))
                    links[i]++;
        end
        // nearest and farthest endpoint; strict compares keep the earliest on ties
        for (int i = 0; i < stored_hits; i++)
        begin
            if (links[i] != 1)
                continue;
            ends++;
            d = span_sq(pos_x[i], pos_y[i], rx, ry);
            if ((!near_ok && d < longint'(near_cut_sq)) || (near_ok && d < near_best))
            begin
                near_ok   = 1'b1;
                near_best = d;
                near_idx  = i;
            end
            if (!far_ok || d > far_best)
            begin
                far_ok   = 1'b1;
                far_best = d;
                far_idx  = i;
            end
        end
        summary.found_two      = (ends == 2);
        summary.endpoint_count = (ends > 127) ? 7'd127 : 7'(ends);
        summary.first_valid    = near_ok;
        if (near_ok)
        begin
            summary.first_index = 6'(near_idx);
            summary.first_x     = COORD_W'(pos_x[near_idx]);
            summary.first_y     = COORD_W'(pos_y[near_idx]);
        end
        summary.second_valid = far_ok;
        if (far_ok)
        begin
            summary.second_index = 6'(far_idx);
            summary.second_x     = COORD_W'(pos_x[far_idx]);
            summary.second_y     = COORD_W'(pos_y[far_idx]);
        end
        summary.overflow = hits_dropped;
        stored_hits      = 0;
        hits_dropped     = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Send one hit. The sender works in bursts; between bursts start may drop for
    // a random gap. Start stays high across back-to-back transactions.
    task automatic send_hit(input cef_in_t h);
        int       gap;
        bit       closes;
        cef_out_t summary;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                start = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        start = 1'b1;
        item  = h;
        // busy is a registered output; a low level at the falling edge holds
        // through the next rising edge, where the transaction is taken
        while (busy)
            @(negedge clk);
        @(posedge clk);
        hits_sent++;
        absorb_hit(h, closes, summary);
        if (closes)
        begin
            clusters_sent++;
            endpoint_q = {endpoint_q, summary};
        end
    endtask

    task automatic pause_sender();
        @(negedge clk);
        start = 1'b0;
    endtask

    // Hold the sender until every expected summary has come back.
    task automatic drain();
        pause_sender();
        while (endpoint_q.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // Register writes only happen with the block idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIST_W-1:0] value);
        drain();
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == REG_NEIGHBOUR)
            link_limit_sq = value;
        else if (idx == REG_NEAR)
            near_cut_sq = value;
    endtask

    function automatic cef_in_t make_hit(int x, int y, int fx, int fy, bit last);
        cef_in_t h;
        h.hit_x    = COORD_W'(x);
        h.hit_y    = COORD_W'(y);
        h.from_x   = COORD_W'(fx);
        h.from_y   = COORD_W'(fy);
        h.last_hit = last;
        return h;
    endfunction

    function automatic int any_coord();
        return int'($urandom_range(0, 2 * FULL_RANGE - 1)) - FULL_RANGE;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic flag_field(input string name, input logic [63:0] want, input logic [63:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= MISMATCH_SHOW)
                $display("%0t mismatch in %s: expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        cef_out_t want;
        if (rst_n && done)
        begin
            results_seen++;
            if (endpoint_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MISMATCH_SHOW)
                    $display("%0t unexpected result transaction", $time);
            end
            else
            begin
                want = endpoint_q.pop_front();
                if (want.overflow)
                    overflow_seen++;
                if (want.found_two)
                    found_two_seen++;
                flag_field("found_two",      want.found_two,      result.found_two);
                flag_field("endpoint_count", want.endpoint_count, result.endpoint_count);
                flag_field("first_valid",    want.first_valid,    result.first_valid);
                flag_field("first_index",    want.first_index,    result.first_index);
                flag_field("first_x",        want.first_x,        result.first_x);
                flag_field("first_y",        want.first_y,        result.first_y);
                flag_field("second_valid",   want.second_valid,   result.second_valid);
                flag_field("second_index",   want.second_index,   result.second_index);
                flag_field("second_x",       want.second_x,       result.second_x);
                flag_field("second_y",       want.second_y,       result.second_y);
                flag_field("overflow",       want.overflow,       result.overflow);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL cluster_endpoint_finder");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Lone hits at the coordinate extremes: no neighbours, so no endpoint.
    task automatic test_lone_hits();
        send_hit(make_hit(FULL_RANGE - 1, -FULL_RANGE, -FULL_RANGE, FULL_RANGE - 1, 1'b1));
        send_hit(make_hit(-FULL_RANGE, FULL_RANGE - 1, FULL_RANGE - 1, -FULL_RANGE, 1'b1));
        send_hit(make_hit(0, 0, 0, 0, 1'b1));
    endtask

    // Pairs: two endpoints; a reference midway ties both, the earlier must win.
    task automatic test_pairs();
        send_hit(make_hit(0, 0, 50, 0, 1'b0));
        send_hit(make_hit(100, 0, 50, 0, 1'b1));
        send_hit(make_hit(-FULL_RANGE, -FULL_RANGE, 0, 0, 1'b0));
        send_hit(make_hit(-FULL_RANGE + 100, -FULL_RANGE + 100, FULL_RANGE - 1, FULL_RANGE - 1,
                          1'b1));
        // coincident hits sit at distance zero
        send_hit(make_hit(777, -777, 0, 0, 1'b0));
        send_hit(make_hit(777, -777, 0, 0, 1'b1));
    endtask

    // Chain of four with a reference near one end, then a star with a hub.
    task automatic test_chain_and_star();
        for (int k = 0; k < 4; k++)
            send_hit(make_hit(1000 + 200 * k, 2000, 900, 2000, k == 3));
        // hub with three spokes: three endpoints, found_two low
        send_hit(make_hit(0, 0, 0, 0, 1'b0));
        send_hit(make_hit(200, 0, 0, 0, 1'b0));
        send_hit(make_hit(-200, 0, 0, 0, 1'b0));
        send_hit(make_hit(0, 200, 0, 0, 1'b1));
    endtask

    // Two hits far from the reference, but too far apart to be neighbours: no endpoint.
    task automatic test_far_reference();
        send_hit(make_hit(FULL_RANGE - 300, FULL_RANGE - 300, -FULL_RANGE, -FULL_RANGE, 1'b0));
        send_hit(make_hit(FULL_RANGE - 100, FULL_RANGE - 100, -FULL_RANGE, -FULL_RANGE, 1'b1));
    endtask

    // Store full: exactly full, one hit dropped, and a dropped closing hit
    // whose reference point must still be used.
    task automatic test_store_full();
        // 32 isolated pairs fill the store: every hit is an endpoint
        for (int k = 0; k < MAX_HITS; k++)
            send_hit(make_hit((k / 2) * 5000 - 80000, (k % 2) * 100, -1000, 0,
                              k == MAX_HITS - 1));
        for (int k = 0; k <= MAX_HITS; k++)
            send_hit(make_hit(k * 150, 0, 0, 0, k == MAX_HITS));
        for (int k = 0; k < MAX_HITS + 2; k++)
            send_hit(make_hit(-k * 150, 3000, -150 * MAX_HITS, 3000, k == MAX_HITS + 1));
    endtask

    // Random clusters: mostly chains with shuffled load order, some noise hits
    // and some fully random clusters.
    task automatic test_random_clusters(input int hit_budget);
        int     n;
        int     step;
        int     sx;
        int     sy;
        int     bx;
        int     by;
        int     fx;
        int     fy;
        int     tmp;
        int     pick;
        int     px [MAX_HITS];
        int     py [MAX_HITS];
        real    reach;
        int     sent;
        sent  = 0;
        reach = $sqrt(real'(link_limit_sq) / 2.0);
        step  = (reach > 20000.0) ? 20000 : int'(reach) - 1;
        if (step < 0)
            step = 0;
        while (sent < hit_budget)
        begin
            n = ($urandom_range(0, 15) == 0) ? $urandom_range(11, 20) : $urandom_range(1, 10);
            if ($urandom_range(0, 5) == 0)
            begin
                // noise cluster over the whole plane
                for (int k = 0; k < n; k++)
                begin
                    px[k] = any_coord();
                    py[k] = any_coord();
                end
            end
            else
            begin
                // chain: steps within the neighbour reach, so adjacent points are neighbours for a nonzero limit
                sx = $urandom_range((step * 3) / 4, step);
                sy = $urandom_range((step * 3) / 4, step);
                if ($urandom_range(0, 1))
                    sx = -sx;
                if ($urandom_range(0, 1))
                    sy = -sy;
                bx = $urandom_range(0, 600000) - 300000;
                by = $urandom_range(0, 600000) - 300000;
                for (int k = 0; k < n; k++)
                begin
                    px[k] = bx + k * sx;
                    py[k] = by + k * sy;
                    if ($urandom_range(0, 9) == 0)
                    begin
                        px[k] = any_coord();
                        py[k] = any_coord();
                    end
                end
                for (int k = n - 1; k > 0; k--)
                begin
                    pick   = $urandom_range(0, k);
                    tmp    = px[k];
                    px[k]  = px[pick];
                    px[pick] = tmp;
                    tmp    = py[k];
                    py[k]  = py[pick];
                    py[pick] = tmp;
                end
            end
            // reference near a random hit, or anywhere
            pick = $urandom_range(0, n - 1);
            if ($urandom_range(0, 1))
            begin
                fx = px[pick] + $urandom_range(0, 2000) - 1000;
                fy = py[pick] + $urandom_range(0, 2000) - 1000;
                if (fx >= FULL_RANGE || fx < -FULL_RANGE)
                    fx = px[pick];
                if (fy >= FULL_RANGE || fy < -FULL_RANGE)
                    fy = py[pick];
            end
            else
            begin
                fx = any_coord();
                fy = any_coord();
            end
            for (int k = 0; k < n; k++)
            begin
                if (k == n - 1)
                    send_hit(make_hit(px[k], py[k], fx, fy, 1'b1));
                else
                    send_hit(make_hit(px[k], py[k], any_coord(), any_coord(), 1'b0));
            end
            sent += n;
        end
    endtask

    // Register settings: zero and 2**41, random values, and the reset values.
    task automatic test_register_sweep();
        write_reg(REG_NEIGHBOUR, '0);
        write_reg(REG_NEAR, DIST_W'(64'd2199023255552));
        test_random_clusters(120);
        write_reg(REG_NEIGHBOUR, DIST_W'(64'd2199023255552));
        write_reg(REG_NEAR, '0);
        test_random_clusters(60);
        write_reg(REG_NEIGHBOUR, DIST_W'($urandom_range(1, 4000000)));
        write_reg(REG_NEAR, DIST_W'({$urandom_range(0, 511), $urandom()}));
        test_random_clusters(160);
        write_reg(REG_NEIGHBOUR, DIST_W'(64'd65536));
        write_reg(REG_NEAR, DIST_W'(64'd65536000000));
        test_random_clusters(170);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        start         = 1'b0;
        item          = '0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        link_limit_sq = DIST_W'(64'd65536);
        near_cut_sq   = DIST_W'(64'd65536000000);
        stored_hits   = 0;
        hits_dropped  = 1'b0;
        burst_left    = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        test_lone_hits();
        test_pairs();
        test_chain_and_star();
        test_far_reference();
        test_store_full();
        drain();
        test_random_clusters(200);
        test_register_sweep();

        // let the last search finish and any stray strobe show up
        drain();
        repeat (DRAIN_CYCLES / 10 + 100) @(negedge clk);

        $display("Sent %0d hits in %0d clusters; %0d summaries checked.",
                 hits_sent, clusters_sent, results_seen);
        $display("Clusters with two endpoints: %0d, with dropped hits: %0d; mismatches: %0d.",
                 found_two_seen, overflow_seen, mismatches);
        if (mismatches == 0 && endpoint_q.size() == 0)
            $display("PASS cluster_endpoint_finder");
        else
            $display("FAIL cluster_endpoint_finder");
        $finish;
    end

endmodule
